### hw/rtl/bca_pkg.sv
// Shared types and constants for the bitmap cluster allocator.
// Holds the controller state type, command/status structs and field widths.
// No dependencies.
package bca_pkg;

   localparam int IDX_W  = 14;
   localparam int CNT_W  = 15;
   localparam int FUNC_W = 2;
   localparam int WORD_W = 64;

   localparam logic [CNT_W-1:0] PART_RESET = 15'd16384;
   localparam logic [CNT_W-1:0] CNT_MAX    = 15'h7FFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_FORMAT = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FMT,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic fmt_wr;
      logic scan_rd;
      logic scan_chk;
      logic alloc_wr;
      logic free_rd;
      logic free_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic fmt_last;
      logic hit;
      logic miss_end;
      logic refused;
      logic rsp_free;
   } sts_type;

endpackage

### hw/rtl/bca_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bca_ctrl.sv
// Controller state machine of the bitmap cluster allocator.
// Depends on bca_pkg; drives the datapath through cmd_type, reads sts_type.
module bca_ctrl
   import bca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [FUNC_W-1:0]   req_func,
   output logic                req_tready,
   output cmd_type             cmd,
   input  sts_type             sts
);
   state_type state_ff, state_in;
   func_type  func;

   assign func = func_type'(req_func);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT, ST_FMT: begin
            if (sts.fmt_last) state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (func)
                  FUNC_ALLOC:  state_in = ST_SCAN;
                  FUNC_FREE:   state_in = ST_FREE_RD;
                  FUNC_FORMAT: state_in = ST_FMT;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            priority if (sts.hit) begin
               state_in = sts.refused ? ST_DONE : ST_ALLOC_WR;
            end else if (sts.miss_end) begin
               state_in = ST_DONE;
            end
         end
         ST_ALLOC_WR: state_in = ST_DONE;
         ST_FREE_RD:  state_in = ST_FREE_WR;
         ST_FREE_WR:  state_in = ST_DONE;
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_FMT: cmd.fmt_wr = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan_rd  = 1'b1;
            cmd.scan_chk = 1'b1;
         end
         ST_ALLOC_WR: cmd.alloc_wr = 1'b1;
         ST_FREE_RD:  cmd.free_rd  = 1'b1;
         ST_FREE_WR:  cmd.free_wr  = 1'b1;
         ST_DONE:     cmd.rsp_load = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

### hw/rtl/bca_datapath.sv
// Datapath of the bitmap cluster allocator: map RAM, scan address, first-set
// search, counters, config register and response register.
// Depends on bca_pkg and bca_ram.
module bca_datapath
   import bca_pkg::*;
#(
   parameter int MAP_BYTES = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [IDX_W-1:0]    req_cluster,
   input  logic                csr_wr_en,
   input  logic [CNT_W-1:0]    csr_wr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [2*IDX_W-1:0]  rsp_data
);
   localparam int WORDS     = (MAP_BYTES * 8 + WORD_W - 1) / WORD_W;
   localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LAST_BITS = MAP_BYTES * 8 - (WORDS - 1) * WORD_W;
   localparam logic [AW-1:0]     LAST_ADDR = AW'(WORDS - 1);
   localparam logic [16:0]       MAP_BITS  = 17'(MAP_BYTES * 8);
   localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

   logic [AW-1:0]      addr_ff, addr_in;
   logic               scan_stop_ff, scan_stop_in;
   logic               rd_valid_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic [AW-1:0]      hit_addr_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [IDX_W-1:0]   cluster_ff;
   logic               free_ok_ff;
   logic [CNT_W-1:0]   part_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   last_found_ff;
   logic [IDX_W-1:0]   got_ff;
   logic               rsp_valid_ff;
   logic [2*IDX_W-1:0] rsp_data_ff;

   logic [WORD_W-1:0]  rd_data;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]  fmt_word;
   logic [AW+7:0]      free_addr_wide;
   logic [AW-1:0]      free_addr;
   logic [7:0]         byte_any;
   logic [2:0]         byte_sel;
   logic [7:0]         byte_val;
   logic [2:0]         bit_sel;
   logic [5:0]         bit_pos;
   logic [AW+19:0]     idx_wide;
   logic [IDX_W-1:0]   hit_idx;

   bca_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // Format pattern: all valid clusters free, clusters 0 and 1 in use.
   always_comb begin
      fmt_word = {WORD_W{1'b1}};
      if (addr_ff == LAST_ADDR) fmt_word = fmt_word & LAST_MASK;
      if (addr_ff == '0) fmt_word = fmt_word & ~(WORD_W'(3));
   end

   assign free_addr_wide = {{AW{1'b0}}, cluster_ff[IDX_W-1:6]};
   assign free_addr      = free_addr_wide[AW-1:0];

   // Lowest set bit: byte first, then bit within the byte.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_any[k] = |rd_data[k*8 +: 8];
      end
      byte_sel = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (byte_any[k]) byte_sel = 3'(k);
      end
      byte_val = rd_data[byte_sel*8 +: 8];
      bit_sel  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (byte_val[b]) bit_sel = 3'(b);
      end
   end

   assign bit_pos  = {byte_sel, bit_sel};
   assign idx_wide = {{IDX_W{1'b0}}, rd_addr_ff, bit_pos};
   assign hit_idx  = idx_wide[IDX_W-1:0];

   assign ram_rd_en   = (cmd.scan_rd && !scan_stop_ff) || cmd.free_rd;
   assign ram_rd_addr = cmd.free_rd ? free_addr : addr_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = fmt_word;
      priority if (cmd.fmt_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.alloc_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = hit_addr_ff;
         ram_wr_data = word_ff;
      end else if (cmd.free_wr) begin
         ram_wr_en   = free_ok_ff;
         ram_wr_addr = free_addr;
         ram_wr_data = rd_data | (WORD_W'(1) << cluster_ff[5:0]);
      end
   end

   always_comb begin
      addr_in      = addr_ff;
      scan_stop_in = scan_stop_ff;
      priority if (cmd.start) begin
         addr_in      = '0;
         scan_stop_in = 1'b0;
      end else if (cmd.fmt_wr) begin
         addr_in = addr_ff + AW'(1);
      end else if (cmd.scan_rd && !scan_stop_ff) begin
         addr_in      = addr_ff + AW'(1);
         scan_stop_in = (addr_ff == LAST_ADDR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         scan_stop_ff  <= 1'b0;
         rd_valid_ff   <= 1'b0;
         part_ff       <= PART_RESET;
         count_ff      <= '0;
         last_found_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         scan_stop_ff <= scan_stop_in;
         rd_valid_ff  <= cmd.scan_rd && !scan_stop_ff && !cmd.start;
         if (csr_wr_en) part_ff <= csr_wr_data;
         if (cmd.alloc_wr && count_ff != CNT_MAX) count_ff <= count_ff + CNT_W'(1);
         if (cmd.scan_chk && sts.hit) last_found_ff <= hit_idx;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_ff;
      if (cmd.start) begin
         cluster_ff <= req_cluster;
         free_ok_ff <= ({3'b000, req_cluster} < MAP_BITS);
         got_ff     <= '0;
      end
      if (cmd.scan_chk && sts.hit) begin
         hit_addr_ff <= rd_addr_ff;
         word_ff     <= rd_data & ~(WORD_W'(1) << bit_pos);
         if (!sts.refused) got_ff <= hit_idx;
      end
      if (cmd.rsp_load) rsp_data_ff <= {last_found_ff, got_ff};
   end

   assign sts.fmt_last = (addr_ff == LAST_ADDR);
   assign sts.hit      = rd_valid_ff && (rd_data != '0);
   assign sts.miss_end = rd_valid_ff && (rd_data == '0) && (rd_addr_ff == LAST_ADDR);
   assign sts.refused  = (count_ff > part_ff);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### hw/rtl/bitmap_cluster_allocator.sv
// Top level of the first-fit bitmap cluster allocator.
// Depends on bca_pkg, bca_ctrl and bca_datapath.
//
// Usage: one command transfer on req_* gives exactly one result transfer on
// rsp_*. req_tuser carries the command (allocate, free, format), req_tdata
// the cluster to free. rsp_tdata returns the allocated cluster (0 when none,
// refused or not an allocate) and the index of the most recent scan hit.
// The map lives in a RAM of 64-bit words, WORDS = ceil(MAP_BYTES/8), each
// word one cluster bit per position; 256 words at the default size.
// Allocate reads one word per cycle from word 0 until a nonzero word shows;
// a hit ends the scan and, unless refused, the word is written back with
// that bit cleared; a full map is scanned to its last word. Free is a
// read-modify-write of one word. Format rewrites every word. The RAM's single
// read port sets the scan rate.
// One command is in work at a time; a result sits in an output register, so
// the next command is taken while it waits for rsp_tready.
// After reset the block runs a format pass with req_tready low; csr writes
// are taken at any time. Reset clears the allocation count, the last-found
// index and sets partition_clusters to 16384.
module bitmap_cluster_allocator
   import bca_pkg::*;
#(
   parameter int MAP_BYTES = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [13:0] cluster_to_free, [15:14] zero
   input  logic [1:0]   req_tuser,   // [1:0] func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [13:0] allocated_cluster, [27:14] last_found
   input  logic         csr_wr_en,
   input  logic [14:0]  csr_wr_data  // partition_clusters
);
   cmd_type            cmd;
   sts_type            sts;
   logic [2*IDX_W-1:0] rsp_data;

   bca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   bca_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_cluster (req_tdata[IDX_W-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_data    (rsp_data)
   );

   assign rsp_tdata = {4'b0000, rsp_data};

endmodule

### hw/rtl/bca_checker.sv
// Port-level assertions for the bitmap cluster allocator, bound to the top.
// Depends only on the top level's ports.
module bca_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while previous one in work");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   a_alloc_matches_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:0] != 14'd0 |-> rsp_tdata[13:0] == rsp_tdata[27:14])
      else $error("allocated cluster differs from last found");

endmodule

bind bitmap_cluster_allocator bca_checker u_bca_checker (.*);

### dv/tb_bitmap_cluster_allocator.sv
// Self-checking testbench for bitmap_cluster_allocator: directed and random command streams,
// a first-fit bitmap predictor, and an in-order check of every rsp transfer.
// Depends on bca_pkg and the bitmap_cluster_allocator RTL.
module tb_bitmap_cluster_allocator
   import bca_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_BYTES    = 2048;
   localparam int NUM_CLUSTERS = MAP_BYTES * 8;
   localparam int NUM_WORDS    = (NUM_CLUSTERS + WORD_W - 1) / WORD_W;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int CHUNK_ITEMS  = 60;

   typedef struct packed {
      logic [IDX_W-1:0] last_found;
      logic [IDX_W-1:0] allocated;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [13:0] cluster_to_free, [15:14] zero
   logic [1:0]  req_tuser = FUNC_NOP;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // [13:0] allocated_cluster, [27:14] last_found
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;

   bitmap_cluster_allocator #(.MAP_BYTES(MAP_BYTES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [NUM_CLUSTERS-1:0] free_bits;
   logic [CNT_W-1:0]        alloc_cnt;
   logic [IDX_W-1:0]        last_hit;
   logic [CNT_W-1:0]        part_limit;
   logic [IDX_W-1:0]        held_clusters[$];
   alloc_rsp_type           expected_rsps[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int err_count = 0;
   int n_checked = 0;
   int n_granted = 0;
   int n_refused = 0;
   int n_freed = 0;
   int n_formats = 0;
   int n_nops = 0;
   int cycle_count = 0;
   alloc_rsp_type got_want;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_rsps.size());
         $display("tb_bitmap_cluster_allocator: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic void map_format();
      free_bits = '1;
      free_bits[1:0] = 2'b00;
      held_clusters.delete();
   endfunction

   function automatic alloc_rsp_type predict_rsp(func_type f, logic [IDX_W-1:0] c);
      alloc_rsp_type r;
      bit found;
      int idx;
      r.allocated = '0;
      found = 0;
      idx = 0;
      case (f)
         FUNC_ALLOC: begin
            for (int w = 0; w < NUM_WORDS && !found; w++) begin
               if (free_bits[w*WORD_W +: WORD_W] != '0) begin
                  for (int b = 0; b < WORD_W && !found; b++) begin
                     if (free_bits[w*WORD_W + b]) begin
                        found = 1;
                        idx = w * WORD_W + b;
                     end
                  end
               end
            end
            if (found) begin
               last_hit = idx[IDX_W-1:0];
               if (alloc_cnt > part_limit) begin
                  n_refused++;
               end else begin
                  free_bits[idx] = 1'b0;
                  if (alloc_cnt != CNT_MAX) alloc_cnt++;
                  r.allocated = idx[IDX_W-1:0];
                  held_clusters.push_back(idx[IDX_W-1:0]);
                  n_granted++;
               end
            end
         end
         FUNC_FREE: begin
            if (int'(c) < NUM_CLUSTERS) free_bits[c] = 1'b1;
            n_freed++;
         end
         FUNC_FORMAT: begin
            map_format();
            n_formats++;
         end
         default: n_nops++;
      endcase
      r.last_found = last_hit;
      return r;
   endfunction

   task automatic send_cmd(input func_type f, input logic [IDX_W-1:0] c);
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {2'b00, c};
      do @(posedge clock); while (!req_tready);
      expected_rsps.push_back(predict_rsp(f, c));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_partition(input logic [CNT_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      part_limit = v;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            err_count++;
            $display("%0t: unexpected rsp transfer, expected none, actual %h", $time, rsp_tdata);
         end else begin
            got_want = expected_rsps.pop_front();
            n_checked++;
            if (rsp_tdata[13:0] !== got_want.allocated) begin
               err_count++;
               $display("%0t: allocated_cluster expected %0d actual %0d",
                        $time, got_want.allocated, rsp_tdata[13:0]);
            end
            if (rsp_tdata[27:14] !== got_want.last_found) begin
               err_count++;
               $display("%0t: last_found expected %0d actual %0d",
                        $time, got_want.last_found, rsp_tdata[27:14]);
            end
         end
      end
   end

   task automatic test_first_fit();
      repeat (3) send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_NOP, 14'h3FFF);
      send_cmd(FUNC_FREE, 14'h3FFF);
      send_cmd(FUNC_FREE, 14'd3);
      send_cmd(FUNC_ALLOC, '0);
   endtask

   // clusters 0 and 1 come back as ordinary indices once freed
   task automatic test_low_clusters();
      send_cmd(FUNC_FREE, 14'd0);
      send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_FREE, 14'd1);
      send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_ALLOC, '0);
   endtask

   task automatic test_refusal();
      drain();
      write_partition('0);
      send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_FREE, 14'd2);
      send_cmd(FUNC_ALLOC, '0);
      drain();
      write_partition(CNT_MAX);
      send_cmd(FUNC_ALLOC, '0);
      drain();
      // limit equal to the count still grants one more
      write_partition(alloc_cnt);
      send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_ALLOC, '0);
      drain();
      write_partition(PART_RESET);
   endtask

   task automatic test_format();
      send_cmd(FUNC_FORMAT, 14'h2AAA);
      send_cmd(FUNC_ALLOC, '0);
      send_cmd(FUNC_FREE, 14'h1555);
      send_cmd(FUNC_ALLOC, '0);
   endtask

   task automatic pick_partition();
      logic [CNT_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = PART_RESET;
         1: v = '0;
         2: v = CNT_MAX;
         3: v = alloc_cnt + CNT_W'($urandom_range(0, 40));
         default: v = CNT_W'($urandom_range(0, 16384));
      endcase
      write_partition(v);
   endtask

   task automatic test_random(input int n_items, input int idle, input int stall);
      int r;
      int j;
      logic [IDX_W-1:0] c;
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n_items; i++) begin
         if (i % CHUNK_ITEMS == 0) begin
            drain();
            pick_partition();
         end
         r = $urandom_range(0, 99);
         if (r < 52) begin
            send_cmd(FUNC_ALLOC, IDX_W'($urandom));
         end else if (r < 76 && held_clusters.size() != 0) begin
            j = $urandom_range(0, held_clusters.size() - 1);
            c = held_clusters[j];
            held_clusters.delete(j);
            send_cmd(FUNC_FREE, c);
         end else if (r < 90) begin
            send_cmd(FUNC_FREE, IDX_W'($urandom_range(0, 16383)));
         end else if (r < 93) begin
            send_cmd(FUNC_FORMAT, IDX_W'($urandom));
         end else if (r < 97) begin
            send_cmd(FUNC_NOP, IDX_W'($urandom));
         end else begin
            send_cmd(FUNC_FREE, IDX_W'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      map_format();
      alloc_cnt = '0;
      last_hit = '0;
      part_limit = PART_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      write_partition(PART_RESET);

      test_first_fit();
      test_low_clusters();
      test_refusal();
      test_format();

      test_random(235, 0, 0);
      test_random(235, 81, 0);
      test_random(235, 0, 81);
      test_random(235, 14, 14);

      drain();
      repeat (300) @(posedge clock);
      $display("covered %0d results: %0d grants, %0d refusals, %0d frees, %0d formats, %0d nops",
               n_checked, n_granted, n_refused, n_freed, n_formats, n_nops);
      $display("partition limits 0, 16384, 32767 and random; four idle/stall mixes");
      if (err_count == 0) begin
         $display("tb_bitmap_cluster_allocator: done, clean");
      end else begin
         $display("tb_bitmap_cluster_allocator: done, errors");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/bca_pkg.sv
hw/rtl/bca_ram.sv
hw/rtl/bca_ctrl.sv
hw/rtl/bca_datapath.sv
hw/rtl/bitmap_cluster_allocator.sv
hw/rtl/bca_checker.sv
dv/tb_bitmap_cluster_allocator.sv
